// ===== hw/rtl/rnta_pkg.sv =====
// Shared constants, command/status types and the digit-to-ASCII function.
`default_nettype none
package rnta_pkg;

    localparam int VALUE_W     = 64;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_W);
    localparam int IN_DATA_W   = ((VALUE_W + RADIX_W + 7) / 8) * 8;
    localparam int MIN_RADIX   = 2;
    localparam int MAX_RADIX   = 36;
    localparam int NUM_DIGITS  = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_ERROR = 8'h00;

    typedef struct packed {
        logic load;       // latch value and radix, clear counters
        logic div_step;   // one shift-subtract step
        logic store;      // write remainder digit, advance count
        logic rd;         // read digit at pointer
        logic emit;       // load output register with digit character
        logic emit_bad;   // load output register with error word
    } cmd_t;

    typedef struct packed {
        logic in_bad;     // incoming radix outside 2..36
        logic bit_last;   // final step of the current division
        logic q_zero;     // quotient is zero
        logic cnt_last;   // digit buffer fills with this store
        logic ptr_zero;   // read pointer at least significant digit
        logic out_free;   // output register can take a word
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d_ext < CHAR_W'(NUM_DIGITS))
            return CHAR_ZERO + d_ext;
        else if (d_ext < CHAR_W'(MAX_RADIX))
            return CHAR_A + (d_ext - CHAR_W'(NUM_DIGITS));
        else
            return CHAR_ZERO;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rnta_datapath.sv =====
// Datapath: bit-serial divider, digit memory, read pointer and output register.
`default_nettype none
module rnta_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rnta_pkg::cmd_t                cmd,
    output rnta_pkg::status_t                  status,
    input  wire logic [rnta_pkg::VALUE_W-1:0]  value,
    input  wire logic [rnta_pkg::RADIX_W-1:0]  radix,
    output logic [rnta_pkg::CHAR_W-1:0]        character,
    output logic                               last,
    output logic                               bad_radix,
    output logic                               out_valid,
    input  wire logic                          out_ready
);

    logic [rnta_pkg::VALUE_W-1:0]    q_reg, q_next;
    logic [rnta_pkg::DIGIT_W-1:0]    r_reg, r_next;
    logic [rnta_pkg::RADIX_W-1:0]    radix_reg;
    logic [rnta_pkg::BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [rnta_pkg::CNT_W-1:0]      cnt_reg;
    logic [rnta_pkg::ADDR_W-1:0]     ptr_reg;
    logic [rnta_pkg::DIGIT_W-1:0]    rd_data_reg;
    logic                            out_valid_reg;
    logic [rnta_pkg::CHAR_W-1:0]     char_reg;
    logic                            last_reg;
    logic                            bad_reg;
    logic [rnta_pkg::DIGIT_W:0]      trial;
    logic [rnta_pkg::DIGIT_W:0]      divisor;
    logic                            ge;

    logic [rnta_pkg::DIGIT_W-1:0]    mem [rnta_pkg::DEPTH];

    // Restoring division step: shift in next dividend bit, subtract if it fits.
    always_comb
    begin
        trial   = {r_reg, q_reg[rnta_pkg::VALUE_W-1]};
        divisor = {1'b0, radix_reg};
        ge      = (trial >= divisor);
        r_next  = ge ? rnta_pkg::DIGIT_W'(trial - divisor)
                     : rnta_pkg::DIGIT_W'(trial);
        q_next  = {q_reg[rnta_pkg::VALUE_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg         <= '0;
            r_reg         <= '0;
            bit_cnt_reg   <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                q_reg       <= value;
                r_reg       <= '0;
                bit_cnt_reg <= '0;
                cnt_reg     <= '0;
            end
            else if (cmd.div_step)
            begin
                q_reg       <= q_next;
                r_reg       <= r_next;
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            else if (cmd.store)
            begin
                r_reg       <= '0;
                bit_cnt_reg <= '0;
                cnt_reg     <= cnt_reg + 1'b1;
                ptr_reg     <= cnt_reg[rnta_pkg::ADDR_W-1:0];
            end
            else if (cmd.emit && ptr_reg != '0)
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end

            if (cmd.emit || cmd.emit_bad)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            radix_reg <= radix;
        if (cmd.store)
            mem[cnt_reg[rnta_pkg::ADDR_W-1:0]] <= r_reg;
        if (cmd.rd)
            rd_data_reg <= mem[ptr_reg];
        if (cmd.emit)
        begin
            char_reg <= rnta_pkg::digit_char(rd_data_reg);
            last_reg <= (ptr_reg == '0);
            bad_reg  <= 1'b0;
        end
        else if (cmd.emit_bad)
        begin
            char_reg <= rnta_pkg::CHAR_ERROR;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
    end

    always_comb
    begin
        status.in_bad   = (radix < rnta_pkg::RADIX_W'(rnta_pkg::MIN_RADIX))
                       || (radix > rnta_pkg::RADIX_W'(rnta_pkg::MAX_RADIX));
        status.bit_last = (bit_cnt_reg == rnta_pkg::BIT_CNT_W'(rnta_pkg::VALUE_W - 1));
        status.q_zero   = (q_reg == '0);
        status.cnt_last = (cnt_reg == rnta_pkg::CNT_W'(rnta_pkg::DEPTH - 1));
        status.ptr_zero = (ptr_reg == '0);
        status.out_free = !out_valid_reg || out_ready;
    end

    assign character = char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rnta_ctrl.sv =====
// Controller: sequences load, division, digit store and most-significant-first emission.
`default_nettype none
module rnta_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rnta_pkg::status_t  status,
    output rnta_pkg::cmd_t          cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_READ,
        ST_EMIT,
        ST_BAD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_bad ? ST_BAD : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.bit_last)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                // stop on zero quotient or full buffer
                state_next = (status.q_zero || status.cnt_last) ? ST_READ : ST_DIV;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.ptr_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_BAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_bad = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/radix_number_to_ascii.sv =====
// Each digit takes the 64 shift-subtract steps of the serial divider plus a store; each
// character then takes a memory read and an output load.
// Throughput: one number at a time; the next word is taken once the last character is
// in the output register (which may still be waiting on m_axis_tready).
// A bad radix returns one error word, loaded once the output register is free.
// Reset: rst_n (async, active low) clears control, counters and output valid, not the memory.
`default_nettype none
module radix_number_to_ascii (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [rnta_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // value[63:0], radix[69:64], zero pad
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [rnta_pkg::CHAR_W-1:0]          m_axis_tdata,   // character[7:0]
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tuser    // bad_radix[0]
);

    rnta_pkg::cmd_t    cmd;
    rnta_pkg::status_t status;

    rnta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rnta_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (s_axis_tdata[rnta_pkg::VALUE_W-1:0]),
        .radix     (s_axis_tdata[rnta_pkg::VALUE_W +: rnta_pkg::RADIX_W]),
        .character (m_axis_tdata),
        .last      (m_axis_tlast),
        .bad_radix (m_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/rnta_checker.sv =====
// Port-level checker for radix_number_to_ascii and its bind.
`default_nettype none
module rnta_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [rnta_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [rnta_pkg::CHAR_W-1:0]     m_axis_tdata,
    input wire logic                            m_axis_tlast,
    input wire logic                            m_axis_tuser
);

    logic [rnta_pkg::RADIX_W-1:0] in_radix;
    assign in_radix = s_axis_tdata[rnta_pkg::VALUE_W +: rnta_pkg::RADIX_W];

    // Held output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // Error word is a single zero character marked last
    a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast
            && m_axis_tdata == rnta_pkg::CHAR_ERROR)
        else $error("bad radix word malformed");

    // Digit words carry only 0-9 or A-Z
    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39)
            || (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h5A))
        else $error("digit character out of alphabet");

    // A bad radix accepted while the output is free drops input ready, then produces its error word
    a_bad_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
            && (in_radix < rnta_pkg::RADIX_W'(rnta_pkg::MIN_RADIX)
                || in_radix > rnta_pkg::RADIX_W'(rnta_pkg::MAX_RADIX))
            && (!m_axis_tvalid || m_axis_tready)
        |=> !s_axis_tready ##1 m_axis_tvalid && m_axis_tuser)
        else $error("bad radix word not returned on time");

endmodule

bind radix_number_to_ascii rnta_checker u_rnta_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== sim/radix_number_to_ascii_tb.sv =====
// Testbench for radix_number_to_ascii: numbers in, one checked ASCII word per digit or error.
`timescale 1ns / 1ps

module radix_number_to_ascii_tb;
    import rnta_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_radix;
    } char_word_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // value[63:0], radix[69:64], zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]     m_axis_tdata;         // character[7:0]
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;         // bad_radix[0]

    char_word_t pending_chars[$];
    char_word_t seen_word;
    char_word_t due_word;
    int         mismatch_count = 0;
    int         stall_left     = 0;
    bit         steady_flow    = 1'b0;

    radix_number_to_ascii u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Queue the digit words one number should produce, most significant digit first.
    function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                           input logic [RADIX_W-1:0] radix);
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] digits [0:DEPTH-1];
        logic [CHAR_W-1:0]  d_ext;
        char_word_t         w;
        int                 n;
        int                 k;
        if (radix < MIN_RADIX || radix > MAX_RADIX)
        begin
            w.character = CHAR_ERROR;
            w.last      = 1'b1;
            w.bad_radix = 1'b1;
            pending_chars.push_back(w);
            return;
        end
        quotient = value;
        n = 0;
        do
        begin
            digits[n] = DIGIT_W'(quotient % VALUE_W'(radix));
            quotient  = quotient / VALUE_W'(radix);
            n++;
        end
        while (quotient != 0 && n < DEPTH);
        for (k = n - 1; k >= 0; k--)
        begin
            d_ext = CHAR_W'(digits[k]);
            w.character = (d_ext < CHAR_W'(NUM_DIGITS)) ? CHAR_ZERO + d_ext
                                                         : CHAR_A + d_ext - CHAR_W'(NUM_DIGITS);
            w.last      = (k == 0);
            w.bad_radix = 1'b0;
            pending_chars.push_back(w);
        end
    endfunction

    // Call at a rising edge; returns at the edge that takes the word, tvalid still high.
    task automatic send_number(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - VALUE_W - RADIX_W){1'b0}}, radix, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_digits(value, radix);
    endtask

    // Output side: random back-pressure, none while steady_flow is set.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0 && !steady_flow)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left    <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_word = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
            if (pending_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: char %h last %b bad_radix %b",
                             seen_word.character, seen_word.last, seen_word.bad_radix);
            end
            else
            begin
                due_word = pending_chars.pop_front();
                if (seen_word.character !== due_word.character ||
                    seen_word.last      !== due_word.last ||
                    seen_word.bad_radix !== due_word.bad_radix)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected char %h last %b bad_radix %b, ",
                                  "got char %h last %b bad_radix %b"},
                                 due_word.character, due_word.last, due_word.bad_radix,
                                 seen_word.character, seen_word.last, seen_word.bad_radix);
                end
            end
        end
    end

    task automatic test_zero_value();
        send_number('0, 6'd2);
        send_number('0, 6'd10);
        send_number('0, 6'd36);
    endtask

    task automatic test_value_extremes();
        send_number('1, 6'd2);
        send_number('1, 6'd10);
        send_number('1, 6'd36);
        send_number(64'd1, 6'd2);
        send_number(64'h8000_0000_0000_0000, 6'd2);
        send_number(64'h0123_4567_89AB_CDEF, 6'd16);
        send_number(64'h5555_5555_5555_5555, 6'd3);
    endtask

    // Edges of the alphabet and the first carry into a second digit.
    task automatic test_digit_alphabet();
        send_number(64'd9, 6'd10);
        send_number(64'd10, 6'd11);
        send_number(64'd35, 6'd36);
        send_number(64'd36, 6'd36);
        send_number(64'd1295, 6'd36);
        send_number(64'd1, 6'd35);
    endtask

    task automatic test_bad_radix();
        send_number('0, 6'd0);
        send_number('1, 6'd1);
        send_number({$urandom, $urandom}, 6'd37);
        send_number({$urandom, $urandom}, 6'd63);
    endtask

    task automatic test_back_to_back();
        int i;
        steady_flow = 1'b1;
        for (i = 0; i < 10; i++)
            send_number(64'($urandom_range(0, 5000)), RADIX_W'($urandom_range(0, 40)));
        steady_flow = 1'b0;
    endtask

    task automatic test_random_numbers();
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        int                 i;
        for (i = 0; i < 120; i++)
        begin
            // The last eight of every forty numbers run with no idling at all.
            steady_flow = (i % 40) >= 32;
            case ($urandom_range(0, 3))
                0: value = {$urandom, $urandom};
                1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
                2: value = 64'($urandom_range(0, 40));
                default: value = {VALUE_W{1'b1}} >> $urandom_range(0, 63);
            endcase
            if ($urandom_range(0, 9) == 0)
                radix = RADIX_W'($urandom_range(0, 63));
            else
                radix = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
            send_number(value, radix);
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_value();
        test_value_extremes();
        test_digit_alphabet();
        test_bad_radix();
        test_back_to_back();
        test_random_numbers();
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        // Let any stray word show up before closing.
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
